/* hw/rtl/swv_pkg.sv */
`timescale 1ns / 1ps
package swv_pkg;

    // front sequencer: read the slot that leaves, then update the sums
    typedef enum logic [0:0] {
        F_IDLE,
        F_UPDATE
    } front_state_t;

    // back sequencer: products, difference, shared bit-serial divide, output
    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SQ,
        B_SUB,
        B_DIV,
        B_OUT
    } back_state_t;

    localparam int unsigned CFG_W        = 8;
    localparam int unsigned VAR_W        = 32;
    localparam int unsigned RESET_LENGTH = 5;

endpackage

/* hw/rtl/swv_ram.sv */
`timescale 1ns / 1ps
module swv_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* hw/rtl/swv_fifo.sv */
`timescale 1ns / 1ps
module swv_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_reg, wr_next;
    logic             rd_reg, rd_next;
    logic [1:0]       cnt_reg, cnt_next;

    // two-entry queue between the front and the back
    always_comb
    begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_reg];
    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
endmodule

/* hw/rtl/swv_front.sv */
`timescale 1ns / 1ps
module swv_front #(
    parameter int MAX_WINDOW  = 128,
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 8,
    parameter int SUM_W       = 23,
    parameter int SQ_W        = 38
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [SAMPLE_BITS-1:0]     sample,
    input  logic                       sample_missing,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [swv_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       fifo_full,
    output logic                       push,
    output logic [CNT_W+SUM_W+SQ_W-1:0] push_data
);
    import swv_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int ENT_W = SAMPLE_BITS + 1;

    front_state_t          state_reg, state_next;
    logic [CFG_W-1:0]      wlen_reg;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [CNT_W-1:0]      filled_reg, filled_next;
    logic [CNT_W-1:0]      vcnt_reg, vcnt_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]       sq_reg, sq_next;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic                  miss_reg;

    logic [CNT_W-1:0]      len_eff;
    logic [CNT_W-1:0]      wp_inc;
    logic                  accept, cfg_wr;
    logic [ENT_W-1:0]      rd_data;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic                  drop_old;
    logic [2*SAMPLE_BITS-1:0] sq_old, sq_new;
    logic                  we;
    logic [ENT_W-1:0]      wdata;

    // effective window length, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = CNT_W'(1);
        end
        else if (32'(wlen_reg) > 32'(MAX_WINDOW))
        begin
            len_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            len_eff = CNT_W'(wlen_reg);
        end
    end

    assign cfg_ready = state_reg == F_IDLE;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_stall  = !(state_reg == F_IDLE && !fifo_full && !cfg_valid);
    assign accept    = in_valid && !in_stall;

    swv_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (wp_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (wp_reg),
        .rdata (rd_data)
    );

    // retire the leaving slot and add the new word
    always_comb
    begin
        old_val  = $signed(rd_data[SAMPLE_BITS-1:0]);
        drop_old = (filled_reg >= len_eff) && rd_data[ENT_W-1] && (vcnt_reg != '0);
        sq_old   = $unsigned((2*SAMPLE_BITS)'(old_val) * (2*SAMPLE_BITS)'(old_val));
        sq_new   = $unsigned((2*SAMPLE_BITS)'($signed(x_reg))
                             * (2*SAMPLE_BITS)'($signed(x_reg)));
        wp_inc   = CNT_W'(wp_reg) + CNT_W'(1);

        state_next  = state_reg;
        wp_next     = wp_reg;
        filled_next = filled_reg;
        vcnt_next   = vcnt_reg;
        sum_next    = sum_reg;
        sq_next     = sq_reg;
        we          = 1'b0;
        wdata       = {!miss_reg, miss_reg ? '0 : x_reg};
        push        = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (cfg_wr)
                begin
                    wp_next     = '0;
                    filled_next = '0;
                    vcnt_next   = '0;
                    sum_next    = '0;
                    sq_next     = '0;
                end
                else if (accept)
                begin
                    state_next = F_UPDATE;
                end
            end
            F_UPDATE:
            begin
                if (drop_old)
                begin
                    sum_next  = sum_next - SUM_W'(old_val);
                    sq_next   = sq_next - SQ_W'(sq_old);
                    vcnt_next = vcnt_next - CNT_W'(1);
                end
                if (filled_reg >= len_eff)
                begin
                    filled_next = len_eff;
                end
                else
                begin
                    filled_next = filled_reg + CNT_W'(1);
                end
                if (!miss_reg)
                begin
                    sum_next  = sum_next + SUM_W'($signed(x_reg));
                    sq_next   = sq_next + SQ_W'(sq_new);
                    vcnt_next = vcnt_next + CNT_W'(1);
                end
                wp_next    = (wp_inc >= len_eff) ? '0 : PTR_W'(wp_inc);
                we         = 1'b1;
                push       = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign push_data = {vcnt_next, sum_next, sq_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wlen_reg   <= CFG_W'(RESET_LENGTH);
            wp_reg     <= '0;
            filled_reg <= '0;
            vcnt_reg   <= '0;
            sum_reg    <= '0;
            sq_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            filled_reg <= filled_next;
            vcnt_reg   <= vcnt_next;
            sum_reg    <= sum_next;
            sq_reg     <= sq_next;
            if (cfg_wr)
            begin
                wlen_reg <= cfg_data;
            end
        end
    end

    // latch the accepted word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample;
            miss_reg <= sample_missing;
        end
    end
endmodule

/* hw/rtl/swv_back.sv */
`timescale 1ns / 1ps
module swv_back #(
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_W       = 8,
    parameter int SUM_W       = 23,
    parameter int SQ_W        = 38
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fifo_empty,
    input  logic [CNT_W+SUM_W+SQ_W-1:0] pop_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [SAMPLE_BITS-1:0]      mean_value,
    output logic [swv_pkg::VAR_W-1:0]   variance_value,
    output logic                        stats_valid,
    output logic [7:0]                  valid_in_window
);
    import swv_pkg::*;

    localparam int SQ_LO  = SQ_W / 2;
    localparam int SQ_HI  = SQ_W - SQ_LO;
    localparam int NUM_W  = SQ_W + CNT_W;
    localparam int SQS_W  = 2 * SUM_W;
    localparam int PROD_W = (NUM_W > SQS_W) ? NUM_W : SQS_W;
    localparam int DEN_W  = 2 * CNT_W;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int MSTART = NUM_W - SUM_W;

    back_state_t            state_reg, state_next;
    logic [CNT_W-1:0]       n_reg;
    logic signed [SUM_W-1:0] s_reg;
    logic [SQ_W-1:0]        q2_reg;
    logic                   neg_reg;
    logic [SUM_W-1:0]       abs_reg;
    logic [SQ_LO+CNT_W-1:0] plo_reg;
    logic [SQ_HI+CNT_W-1:0] phi_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [PROD_W-1:0]      num_reg, ssq_reg;
    logic [NUM_W-1:0]       dvd_reg;
    logic [DEN_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       mdvd_reg;
    logic [CNT_W-1:0]       mrem_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   flag_reg;

    logic                   ov_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;
    logic [VAR_W-1:0]       var_reg;
    logic                   sv_reg;
    logic [7:0]             viw_reg;

    logic                   out_free, load_out;
    logic [DEN_W:0]         rsh;
    logic [CNT_W:0]         msh;
    logic [SUM_W-1:0]       mq_signed;

    assign out_free = !ov_reg || !out_stall;

    // next state of the back sequencer
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop        = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = (n_reg >= CNT_W'(2)) ? B_SQ : B_OUT;
            end
            B_SQ:  state_next = B_SUB;
            B_SUB: state_next = B_DIV;
            B_DIV:
            begin
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // one quotient bit per cycle for both divides
    assign rsh = {rem_reg, dvd_reg[NUM_W-1]};
    assign msh = {mrem_reg, mdvd_reg[SUM_W-1]};
    assign mq_signed = neg_reg ? (SUM_W'(0) - mdvd_reg) : mdvd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    {n_reg, s_reg, q2_reg} <= pop_data;
                end
            end
            B_MUL:
            begin
                plo_reg  <= (SQ_LO+CNT_W)'(q2_reg[SQ_LO-1:0]) * (SQ_LO+CNT_W)'(n_reg);
                phi_reg  <= (SQ_HI+CNT_W)'(q2_reg[SQ_W-1:SQ_LO]) * (SQ_HI+CNT_W)'(n_reg);
                den_reg  <= DEN_W'(n_reg) * DEN_W'(n_reg - CNT_W'(1));
                neg_reg  <= s_reg[SUM_W-1];
                abs_reg  <= s_reg[SUM_W-1] ? SUM_W'(-s_reg) : SUM_W'(s_reg);
                flag_reg <= n_reg >= CNT_W'(2);
                dvd_reg  <= '0;
                mdvd_reg <= '0;
            end
            B_SQ:
            begin
                ssq_reg <= PROD_W'(abs_reg) * PROD_W'(abs_reg);
                num_reg <= (PROD_W'(phi_reg) << SQ_LO) + PROD_W'(plo_reg);
            end
            B_SUB:
            begin
                dvd_reg  <= (num_reg >= ssq_reg) ? NUM_W'(num_reg - ssq_reg) : '0;
                rem_reg  <= '0;
                mdvd_reg <= abs_reg;
                mrem_reg <= '0;
                step_reg <= '0;
            end
            B_DIV:
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (rsh >= {1'b0, den_reg})
                begin
                    rem_reg <= DEN_W'(rsh - {1'b0, den_reg});
                    dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rsh[DEN_W-1:0];
                    dvd_reg <= {dvd_reg[NUM_W-2:0], 1'b0};
                end
                if (32'(step_reg) >= 32'(MSTART))
                begin
                    if (msh >= {1'b0, n_reg})
                    begin
                        mrem_reg <= CNT_W'(msh - {1'b0, n_reg});
                        mdvd_reg <= {mdvd_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        mrem_reg <= msh[CNT_W-1:0];
                        mdvd_reg <= {mdvd_reg[SUM_W-2:0], 1'b0};
                    end
                end
            end
            B_OUT:
            begin
                if (load_out)
                begin
                    mean_reg <= SAMPLE_BITS'(mq_signed);
                    var_reg  <= (64'(dvd_reg) > 64'h0000_0000_FFFF_FFFF) ? '1 : VAR_W'(dvd_reg);
                    sv_reg   <= flag_reg;
                    viw_reg  <= 8'(n_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = ov_reg;
    assign mean_value      = mean_reg;
    assign variance_value  = var_reg;
    assign stats_valid     = sv_reg;
    assign valid_in_window = viw_reg;

`ifndef SYNTHESIS
    a_flag_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && load_out && flag_reg) |-> (n_reg >= CNT_W'(2)))
        else $error("stats flag with fewer than two samples");
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_OUT && !flag_reg) |-> (dvd_reg == '0 && mdvd_reg == '0))
        else $error("nonzero result without statistics");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == B_IDLE && !fifo_empty))
        else $error("queue popped while busy");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(var_reg) && $stable(mean_reg)))
        else $error("held result overwritten");
`endif
endmodule

/* hw/rtl/sliding_window_variance_core.sv */
`timescale 1ns / 1ps
// Rolling variance over the last window_length samples (1..MAX_WINDOW).
// Each accepted word gives one result: the mean truncated toward zero, the
// unbiased variance in squared sample units and the count of valid samples.
// The front reads the leaving ring slot, then updates the sums, taking no
// new word meanwhile; the back divides bit-serially, but goes from multiply
// to output for a word with fewer than two valid samples. A two-word queue
// and an output register let both sides run and stall independently.
// Writing window_length clears the window and is only taken while the
// front is idle.
module sliding_window_variance_core #(
    parameter int MAX_WINDOW  = 128,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic                      sample_missing,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SAMPLE_BITS-1:0]    mean_value,
    output logic [swv_pkg::VAR_W-1:0] variance_value,
    output logic                      stats_valid,
    output logic [7:0]                valid_in_window,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [swv_pkg::CFG_W-1:0] cfg_data
);
    import swv_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int SQ_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int Q_W   = CNT_W + SUM_W + SQ_W;

    logic           fifo_full, fifo_empty, push, pop;
    logic [Q_W-1:0] push_data, pop_data;

    swv_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .SQ_W        (SQ_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .sample_missing (sample_missing),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_data      (push_data)
    );

    swv_fifo #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    swv_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .SQ_W        (SQ_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_empty      (fifo_empty),
        .pop_data        (pop_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_value      (mean_value),
        .variance_value  (variance_value),
        .stats_valid     (stats_valid),
        .valid_in_window (valid_in_window)
    );
endmodule

/* bench/sliding_window_variance_core_test.sv */
`timescale 1ns / 1ps
module sliding_window_variance_core_test;

    import swv_pkg::*;

    localparam int RING_DEPTH  = 128;
    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 80;

    typedef struct {
        logic [15:0]      mean;
        logic [VAR_W-1:0] variance;
        logic             ok;
        logic [7:0]       count;
    } window_stats_t;

    // keeps its own window and the queue of stats still to come out
    class variance_scoreboard;
        bit               slot_ok [RING_DEPTH];
        longint           slot_val [RING_DEPTH];
        int unsigned      length_reg;
        int unsigned      head;
        int unsigned      filled;
        int unsigned      present;
        longint           sum;
        longint           square_sum;
        window_stats_t    pending_stats[$];
        int               errors;
        int               results_seen;

        function new();
            length_reg = RESET_LENGTH;
            errors = 0;
            results_seen = 0;
            clear();
        endfunction

        function void clear();
            head = 0;
            filled = 0;
            present = 0;
            sum = 0;
            square_sum = 0;
        endfunction

        function void set_length(logic [CFG_W-1:0] value);
            length_reg = value;
            clear();
        endfunction

        // update the window with one accepted word and queue its stats
        function void note_word(logic [15:0] raw, logic missing);
            int unsigned   len;
            int unsigned   wp;
            longint        x;
            longint        n;
            longint        num;
            longint        q;
            window_stats_t e;
            len = (length_reg < 1) ? 1 : ((length_reg > RING_DEPTH) ? RING_DEPTH : length_reg);
            wp = head % RING_DEPTH;
            x = longint'($signed(raw));
            if (wp >= len)
                wp = 0;
            if (filled >= len)
            begin
                if (slot_ok[wp] && present > 0)
                begin
                    sum -= slot_val[wp];
                    square_sum -= slot_val[wp] * slot_val[wp];
                    present--;
                end
                filled = len;
            end
            else
                filled++;
            slot_ok[wp] = !missing;
            slot_val[wp] = missing ? 0 : x;
            if (!missing)
            begin
                sum += x;
                square_sum += x * x;
                present++;
            end
            wp++;
            if (wp >= len)
                wp = 0;
            head = wp;
            e.mean = '0;
            e.variance = '0;
            e.ok = 1'b0;
            e.count = present[7:0];
            if (present >= 2)
            begin
                n = present;
                num = n * square_sum - sum * sum;
                if (num < 0)
                    num = 0;
                q = num / (n * (n - 1));
                if (q > 64'hFFFF_FFFF)
                    q = 64'hFFFF_FFFF;
                e.variance = q[VAR_W-1:0];
                e.mean = 16'(sum / n);
                e.ok = 1'b1;
            end
            pending_stats = {pending_stats, e};
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(window_stats_t got);
            window_stats_t e;
            results_seen++;
            if (pending_stats.size() == 0)
            begin
                $display("%0t: unexpected result word mean %h var %h", $realtime,
                         got.mean, got.variance);
                errors++;
                return;
            end
            e = pending_stats[0];
            pending_stats.delete(0);
            if (got.mean !== e.mean)
            begin
                $display("%0t: mean expected %h actual %h", $realtime, e.mean, got.mean);
                errors++;
            end
            if (got.variance !== e.variance)
            begin
                $display("%0t: variance expected %h actual %h", $realtime, e.variance,
                         got.variance);
                errors++;
            end
            if (got.ok !== e.ok)
            begin
                $display("%0t: stats_valid expected %b actual %b", $realtime, e.ok, got.ok);
                errors++;
            end
            if (got.count !== e.count)
            begin
                $display("%0t: valid_in_window expected %0d actual %0d", $realtime,
                         e.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [15:0]         sample;
    logic                sample_missing;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [15:0]         mean_value;
    logic [VAR_W-1:0]    variance_value;
    logic                stats_valid;
    logic [7:0]          valid_in_window;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data;

    variance_scoreboard  board;
    bit                  calm;
    int                  words_sent = 0;
    int                  cfg_writes;
    int                  idle_cycles = 0;

    sliding_window_variance_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .sample_missing  (sample_missing),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mean_value      (mean_value),
        .variance_value  (variance_value),
        .stats_valid     (stats_valid),
        .valid_in_window (valid_in_window),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    // receiver stalls at random
    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 36);
    end

    // monitors for accepted words and results, and the idle watchdog
    always @(posedge clk)
    begin
        window_stats_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                board.note_word(sample, sample_missing);
                words_sent++;
            end
            if (out_valid && !out_stall)
            begin
                got.mean = mean_value;
                got.variance = variance_value;
                got.ok = stats_valid;
                got.count = valid_in_window;
                board.check_word(got);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no word moved for %0d cycles", $realtime,
                         STALL_LIMIT);
                $display("FAIL sliding_window_variance_core");
                $finish;
            end
        end
    end

    // send one sample word, at random with a random gap in front
    task automatic send_word(logic [15:0] value, logic missing);
        if (!calm && ($urandom_range(99) < 36))
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        sample_missing <= missing;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drain, then write the window length while idle
    task automatic write_length(logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_stats.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_length(value);
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_words(int count, int missing_pct);
        for (int i = 0; i < count; i++)
            send_word(pick_sample(), $urandom_range(99) < missing_pct);
    endtask

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] lengths [8];
        board = new();
        calm = 1'b0;
        cfg_writes = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        sample_missing = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, default length: lone samples, extremes, missing words
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b1);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        send_word(16'h0000, 1'b0);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h1234, 1'b1);
        send_word(16'h0001, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(16'h8000, 1'b1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0003, 1'b0);

        // length zero acts as one, then two
        write_length(8'd0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'h8000, 1'b0);
        write_length(8'd2);
        send_word(16'h8000, 1'b0);
        send_word(16'h7FFF, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0005, 1'b0);

        // full window of alternating extremes, then oversized length
        write_length(8'd128);
        for (int i = 0; i < 130; i++)
            send_word(i[0] ? 16'h7FFF : 16'h8000, 1'b0);
        write_length(8'd255);
        random_words(140, 10);

        // random phases over several lengths
        lengths = '{8'd1, 8'd3, 8'd5, 8'd17, 8'd64, 8'd127, 8'd4, 8'd9};
        for (int p = 0; p < 8; p++)
        begin
            write_length(lengths[p]);
            calm = (p == 3);
            random_words(50, (p == 6) ? 60 : 15);
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_stats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (board.pending_stats.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $realtime,
                     board.pending_stats.size());
            board.errors++;
        end

        $display("covered %0d sample words and %0d results over %0d length writes",
                 words_sent, board.results_seen, cfg_writes);
        $display("lengths 0..255 incl. saturation, extremes, missing samples, random stalls");
        if (board.errors == 0)
            $display("PASS sliding_window_variance_core");
        else
            $display("FAIL sliding_window_variance_core");
        $finish;
    end

endmodule

/* sliding_window_variance_core.f */
hw/rtl/swv_pkg.sv
hw/rtl/swv_ram.sv
hw/rtl/swv_fifo.sv
hw/rtl/swv_front.sv
hw/rtl/swv_back.sv
hw/rtl/sliding_window_variance_core.sv
bench/sliding_window_variance_core_test.sv
